FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, empty when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising edge outside reset
`define ASSERT_PROP(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (prop)) \
    else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(name, clock, reset, cond) \
  name: assert property (@(posedge clock) disable iff (reset) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clock, reset, prop)
`define ASSERT_NEVER(name, clock, reset, cond)

`endif

`endif

FILE: rtl/chsc_pkg.sv
// ---------------------------------------------------------------------------
// chsc_pkg
// fixed widths, codes and types of the census stereo cost block
// ---------------------------------------------------------------------------
package chsc_pkg;

  localparam int PIX_W   = 8;   // grey value
  localparam int DIM_W   = 9;   // image size registers and coordinates
  localparam int DCNT_W  = 7;   // disparity count register
  localparam int DISP_W  = 6;   // disparity of one result
  localparam int COST_W  = 8;   // hamming count
  localparam int CFG_W   = 9;   // config write data
  localparam int CIDX_W  = 2;   // config register index
  localparam int MIN_DIM = 15;  // smallest image side

  // config register indexes
  localparam logic [CIDX_W-1:0] REG_DISP_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_IMAGE_ROWS = 2'd1;
  localparam logic [CIDX_W-1:0] REG_IMAGE_COLS = 2'd2;

  // command modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] left;
    logic [PIX_W-1:0] right;
  } pix_pair_t;

endpackage

FILE: rtl/chsc_pixel_store.sv
// ---------------------------------------------------------------------------
// chsc_pixel_store
// left and right pixel memories, one write and one registered read a cycle
// ---------------------------------------------------------------------------
module chsc_pixel_store #(
  parameter int AW = 16
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  chsc_pkg::pix_pair_t wdata,
  input  logic [AW-1:0]       raddr,
  output chsc_pkg::pix_pair_t rdata
);

  logic [chsc_pkg::PIX_W-1:0] mem_l [2**AW];
  logic [chsc_pkg::PIX_W-1:0] mem_r [2**AW];

  // both sides share one address, so one block writes and reads them
  always_ff @(posedge clk) begin
    if (we) begin
      mem_l[waddr] <= wdata.left;
      mem_r[waddr] <= wdata.right;
    end
    rdata.left  <= mem_l[raddr];
    rdata.right <= mem_r[raddr];
  end

endmodule

FILE: rtl/census_hamming_stereo_cost.sv
// ---------------------------------------------------------------------------
// census_hamming_stereo_cost
// census transform stereo matching cost, hamming form, over two pixel stores
// ---------------------------------------------------------------------------
//  channel   | handshake                 | word
//  ----------+---------------------------+----------------------------------
//  command   | start, busy               | mode, row, column, left_pixel,
//            |                           | right_pixel
//  result    | result_valid (strobe)     | disparity, cost, out_of_range, last
//  config    | cfg_write                 | cfg_index, cfg_data
//
//  a load word is written to both stores at the accepting edge, busy stays low
//  a query first reduces row and column modulo image_rows and image_cols,
//  then fills both windows and compares them for disparity zero; each
//  further in-range disparity reads one new right column before its
//  compare, and an out-of-range one gives its result without reads; the
//  single memory read port, one pixel pair a cycle, sets the query time
//  synchronous active-high reset clears the sequencer and config registers;
//  the stores are not cleared
//  results are strobed for one cycle each and cannot be stalled
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module census_hamming_stereo_cost #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256,
  parameter int MAX_DISP = 64,
  parameter int WINDOW   = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  // command
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode,
  input  logic [7:0]                          row,
  input  logic [7:0]                          column,
  input  logic [chsc_pkg::PIX_W-1:0]          left_pixel,
  input  logic [chsc_pkg::PIX_W-1:0]          right_pixel,
  // results
  output logic                                result_valid,
  output logic [chsc_pkg::DISP_W-1:0]         disparity,
  output logic [chsc_pkg::COST_W-1:0]         cost,
  output logic                                out_of_range,
  output logic                                last,
  // configuration
  input  logic                                cfg_write,
  input  logic [chsc_pkg::CIDX_W-1:0]         cfg_index,
  input  logic [chsc_pkg::CFG_W-1:0]          cfg_data
);

  // store addressing: row bits above column bits
  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int AW = RW + CW;

  // window geometry
  localparam int HALF  = WINDOW / 2;
  localparam int WW    = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int CTR_K = WINDOW - 1 - HALF;  // compare step that sees the centre column

  // register limits, capped by what the 9-bit fields can hold
  localparam int ROW_CAP  = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
  localparam int COL_CAP  = (MAX_COLS > 511) ? 511 : MAX_COLS;
  localparam int ROW_RST  = (ROW_CAP < 256) ? ROW_CAP : 256;
  localparam int COL_RST  = (COL_CAP < 256) ? COL_CAP : 256;
  localparam int DISP_RST = (MAX_DISP < 64) ? MAX_DISP : 64;

  localparam int DW = chsc_pkg::DIM_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MODY  = 9'b000000010,
    S_MODX  = 9'b000000100,
    S_START = 9'b000001000,
    S_READ  = 9'b000010000,
    S_DRAIN = 9'b000100000,
    S_PREP  = 9'b001000000,
    S_CMP   = 9'b010000000,
    S_NEXT  = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [chsc_pkg::DCNT_W-1:0] disp_count;
  logic [DW-1:0]               image_rows;
  logic [DW-1:0]               image_cols;

  // query coordinates and read pointers
  logic [DW-1:0]               yq;
  logic [DW-1:0]               xq;
  logic [DW-1:0]               row_start;
  logic [DW-1:0]               qrow;
  logic [DW-1:0]               qcol;
  logic [WW-1:0]               rrow;
  logic [CNT_W-1:0]            ccnt;
  logic                        load_left;
  logic                        rd_valid;
  logic                        rd_col_end;

  // windows, columns under fill and centre values
  logic [chsc_pkg::PIX_W-1:0]  lwin [WINDOW][WINDOW];
  logic [chsc_pkg::PIX_W-1:0]  rwin [WINDOW][WINDOW];
  logic [chsc_pkg::PIX_W-1:0]  lcol [WINDOW];
  logic [chsc_pkg::PIX_W-1:0]  rcol [WINDOW];
  logic [chsc_pkg::PIX_W-1:0]  lcol_next [WINDOW];
  logic [chsc_pkg::PIX_W-1:0]  rcol_next [WINDOW];
  logic [chsc_pkg::PIX_W-1:0]  lc;
  logic [chsc_pkg::PIX_W-1:0]  rc;

  // compare pass
  logic [WW-1:0]               kcnt;
  logic [chsc_pkg::COST_W-1:0] acc;
  logic [chsc_pkg::COST_W-1:0] acc_next;
  logic [WINDOW-1:0]           cmp_bits;
  logic [chsc_pkg::DISP_W-1:0] d;
  logic                        d_last;
  logic                        d_oor;

  // shared subtract and compare unit
  logic [DW:0]                 sub_a;
  logic [DW:0]                 sub_b;
  logic [DW:0]                 sub_d;
  logic                        sub_ge;

  // store ports
  logic                        st_we;
  logic [AW-1:0]               st_waddr;
  logic [AW-1:0]               st_raddr;
  chsc_pkg::pix_pair_t         st_wdata;
  chsc_pkg::pix_pair_t         st_rdata;

  logic                        accept;
  logic [DW-1:0]               qrow_inc;
  logic [DW-1:0]               qcol_dec;
  logic [DW:0]                 row_start_wrap;
  logic [DW-1:0]               row_start_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // --- pixel stores ---------------------------------------------------------
  // load words are written at the accepting edge; out-of-store loads dropped
  assign st_we = accept && (mode == chsc_pkg::MODE_LOAD) &&
                 (32'(row) < 32'(MAX_ROWS)) && (32'(column) < 32'(MAX_COLS));
  assign st_waddr       = {RW'(row), CW'(column)};
  assign st_wdata.left  = left_pixel;
  assign st_wdata.right = right_pixel;
  assign st_raddr       = {RW'(qrow), CW'(qcol)};

  chsc_pixel_store #(
    .AW (AW)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // --- configuration --------------------------------------------------------
  // each value saturates into its legal range; the disparity count uses only the low DCNT_W data bits
  always_ff @(posedge clk) begin
    if (rst) begin
      disp_count <= chsc_pkg::DCNT_W'(DISP_RST);
      image_rows <= DW'(ROW_RST);
      image_cols <= DW'(COL_RST);
    end else if (cfg_write) begin
      case (cfg_index)
        chsc_pkg::REG_DISP_COUNT: begin
          if (cfg_data[chsc_pkg::DCNT_W-1:0] == '0) begin
            disp_count <= chsc_pkg::DCNT_W'(1);
          end else if (32'(cfg_data[chsc_pkg::DCNT_W-1:0]) > 32'(MAX_DISP)) begin
            disp_count <= chsc_pkg::DCNT_W'(MAX_DISP);
          end else begin
            disp_count <= cfg_data[chsc_pkg::DCNT_W-1:0];
          end
        end
        chsc_pkg::REG_IMAGE_ROWS: begin
          if (32'(cfg_data) < 32'(chsc_pkg::MIN_DIM)) begin
            image_rows <= DW'(chsc_pkg::MIN_DIM);
          end else if (32'(cfg_data) > 32'(ROW_CAP)) begin
            image_rows <= DW'(ROW_CAP);
          end else begin
            image_rows <= cfg_data;
          end
        end
        chsc_pkg::REG_IMAGE_COLS: begin
          if (32'(cfg_data) < 32'(chsc_pkg::MIN_DIM)) begin
            image_cols <= DW'(chsc_pkg::MIN_DIM);
          end else if (32'(cfg_data) > 32'(COL_CAP)) begin
            image_cols <= DW'(COL_CAP);
          end else begin
            image_cols <= cfg_data;
          end
        end
        default: begin
          // index beyond the register list: no effect
        end
      endcase
    end
  end

  // --- shared subtractor ----------------------------------------------------
  // modulo steps for row and column, then the wrap of the first column
  always_comb begin
    case (state)
      S_MODY: begin
        sub_a = {1'b0, yq};
        sub_b = {1'b0, image_rows};
      end
      S_MODX: begin
        sub_a = {1'b0, xq};
        sub_b = {1'b0, image_cols};
      end
      default: begin
        sub_a = {1'b0, xq} + (DW+1)'(HALF);
        sub_b = {1'b0, image_cols};
      end
    endcase
    sub_d  = sub_a - sub_b;
    sub_ge = (sub_a >= sub_b);
  end

  // top row of the window, wrapped into the image
  assign row_start_wrap = {1'b0, yq} + {1'b0, image_rows} - (DW+1)'(HALF);
  assign row_start_next = (yq >= DW'(HALF)) ? (yq - DW'(HALF)) : row_start_wrap[DW-1:0];

  // pointer steps with wrap-around
  assign qrow_inc = (qrow == image_rows - DW'(1)) ? '0 : (qrow + DW'(1));
  assign qcol_dec = (qcol == '0) ? (image_cols - DW'(1)) : (qcol - DW'(1));

  // per-disparity flags
  assign d_last = ({1'b0, d} + chsc_pkg::DCNT_W'(1)) == disp_count;
  assign d_oor  = (DW'(d) > xq);

  // --- compare unit ---------------------------------------------------------
  // one window column a step: census bits of both sides, xor, count
  always_comb begin
    for (int r = 0; r < WINDOW; r++) begin
      cmp_bits[r] = ((lc > lwin[WINDOW-1][r]) != (rc > rwin[WINDOW-1][r])) &&
                    !((kcnt == WW'(CTR_K)) && (r == HALF));
    end
    acc_next = acc + chsc_pkg::COST_W'($countones(cmp_bits));
  end

  // fill columns: newest read enters at the bottom
  always_comb begin
    for (int r = 0; r < WINDOW - 1; r++) begin
      lcol_next[r] = lcol[r+1];
      rcol_next[r] = rcol[r+1];
    end
    lcol_next[WINDOW-1] = st_rdata.left;
    rcol_next[WINDOW-1] = st_rdata.right;
  end

  // --- sequencer ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rd_valid     <= (state == S_READ);
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (mode == chsc_pkg::MODE_QUERY)) begin
            state <= S_MODY;
          end
        end
        S_MODY: begin
          if (!sub_ge) begin
            state <= S_MODX;
          end
        end
        S_MODX: begin
          if (!sub_ge) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_READ;
        end
        S_READ: begin
          if ((rrow == WW'(WINDOW - 1)) && (ccnt == CNT_W'(1))) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_PREP;
        end
        S_PREP: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (kcnt == WW'(WINDOW - 1)) begin
            result_valid <= 1'b1;
            state        <= d_last ? S_IDLE : S_NEXT;
          end
        end
        S_NEXT: begin
          if (d_oor) begin
            result_valid <= 1'b1;
            if (d_last) begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk) begin
    rd_col_end <= (rrow == WW'(WINDOW - 1));
    case (state)
      S_IDLE: begin
        yq <= DW'(row);
        xq <= DW'(column);
        d  <= '0;
      end
      S_MODY: begin
        if (sub_ge) begin
          yq <= sub_d[DW-1:0];
        end
      end
      S_MODX: begin
        if (sub_ge) begin
          xq <= sub_d[DW-1:0];
        end
      end
      S_START: begin
        // full fill of both windows, rightmost column first
        row_start <= row_start_next;
        qrow      <= row_start_next;
        qcol      <= sub_ge ? sub_d[DW-1:0] : sub_a[DW-1:0];
        rrow      <= '0;
        ccnt      <= CNT_W'(WINDOW);
        load_left <= 1'b1;
      end
      S_READ: begin
        if (rrow == WW'(WINDOW - 1)) begin
          rrow <= '0;
          qrow <= row_start;
          qcol <= qcol_dec;
          ccnt <= ccnt - CNT_W'(1);
        end else begin
          rrow <= rrow + WW'(1);
          qrow <= qrow_inc;
        end
      end
      S_PREP: begin
        lc   <= lwin[HALF][HALF];
        rc   <= rwin[HALF][HALF];
        kcnt <= '0;
        acc  <= '0;
      end
      S_CMP: begin
        kcnt <= kcnt + WW'(1);
        acc  <= acc_next;
        if (kcnt == WW'(WINDOW - 1)) begin
          disparity    <= d;
          cost         <= acc_next;
          out_of_range <= 1'b0;
          last         <= d_last;
          d            <= d + chsc_pkg::DISP_W'(1);
        end
      end
      S_NEXT: begin
        if (d_oor) begin
          disparity    <= d;
          cost         <= '0;
          out_of_range <= 1'b1;
          last         <= d_last;
          d            <= d + chsc_pkg::DISP_W'(1);
        end else begin
          // one new right column, one place further left
          rrow      <= '0;
          ccnt      <= CNT_W'(1);
          load_left <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // windows: column fill from the store, or rotation during compare
  always_ff @(posedge clk) begin
    if (rd_valid) begin
      lcol <= lcol_next;
      rcol <= rcol_next;
      if (rd_col_end) begin
        for (int c = 1; c < WINDOW; c++) begin
          rwin[c] <= rwin[c-1];
        end
        rwin[0] <= rcol_next;
        if (load_left) begin
          for (int c = 1; c < WINDOW; c++) begin
            lwin[c] <= lwin[c-1];
          end
          lwin[0] <= lcol_next;
        end
      end
    end else if (state == S_CMP) begin
      // full turn over WINDOW steps restores both windows
      for (int c = 1; c < WINDOW; c++) begin
        lwin[c] <= lwin[c-1];
        rwin[c] <= rwin[c-1];
      end
      lwin[0] <= lwin[WINDOW-1];
      rwin[0] <= rwin[WINDOW-1];
    end
  end

  // --- checks ---------------------------------------------------------------
  `ASSERT_PROP(a_last_ends_query, clk, rst, result_valid && last |=> !result_valid)
  `ASSERT_PROP(a_oor_zero_cost, clk, rst, result_valid && out_of_range |-> cost == '0)
  `ASSERT_PROP(a_busy_mid_query, clk, rst, result_valid && !last |-> busy)
  `ASSERT_PROP(a_query_goes_busy, clk, rst,
               start && !busy && (mode == chsc_pkg::MODE_QUERY) |=> busy)

endmodule
